>>> hdl/pseudocolor_level_map_unit_macros.svh
// Assertion macros shared by the pseudocolor level map checker
`ifndef PSEUDOCOLOR_LEVEL_MAP_UNIT_MACROS_SVH
`define PSEUDOCOLOR_LEVEL_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PLMU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pseudocolor level map assertion failed");

// Next-cycle implication, disabled while reset is low
`define PLMU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pseudocolor level map assertion failed");

`endif

>>> hdl/plmu_pkg.sv
// Types, constants and tables of the pseudocolor level map
`default_nettype none
package plmu_pkg;

    // Level count limit and search width
    localparam int MAX_LEVELS = 256;
    localparam int SRCH_BITS  = 10;

    // Reciprocal table for division by the level count
    localparam int RCP_SHIFT = 25;
    localparam int RCP_W     = 26;

    // Register indexes
    localparam logic [2:0] REG_MAP_MODE     = 3'd0;
    localparam logic [2:0] REG_LOW_VALUE    = 3'd1;
    localparam logic [2:0] REG_MID_VALUE    = 3'd2;
    localparam logic [2:0] REG_HIGH_VALUE   = 3'd3;
    localparam logic [2:0] REG_COLOR_LOW    = 3'd4;
    localparam logic [2:0] REG_COLOR_MIDDLE = 3'd5;
    localparam logic [2:0] REG_COLOR_HIGH   = 3'd6;
    localparam logic [2:0] REG_LEVEL_COUNT  = 3'd7;

    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [50:0] COLOR_WHITE = {Q16_ONE, Q16_ONE, Q16_ONE};

    typedef logic [16:0] t_chan;
    typedef logic [50:0] t_color;
    typedef logic [RCP_W-1:0] t_rcp_tbl [0:MAX_LEVELS];

    // floor(2^RCP_SHIFT / n) for every level count from one to MAX_LEVELS, by restoring long division
    function automatic t_rcp_tbl build_rcp();
        t_rcp_tbl         tbl;
        logic [RCP_W-1:0] rem;
        logic [RCP_W-1:0] quo;
        tbl[0] = '0;
        for (int k = 1; k <= MAX_LEVELS; k++) begin
            rem = '0;
            quo = '0;
            for (int b = RCP_SHIFT; b >= 0; b--) begin
                rem = {rem[RCP_W-2:0], (b == RCP_SHIFT)};
                quo = {quo[RCP_W-2:0], 1'b0};
                if (rem >= RCP_W'(k)) begin
                    rem    = rem - RCP_W'(k);
                    quo[0] = 1'b1;
                end
            end
            tbl[k] = quo;
        end
        return tbl;
    endfunction

    localparam t_rcp_tbl RCP_TBL = build_rcp();

    // Extract one Q16 channel and clamp it at one
    function automatic t_chan chan_q16(input t_color c, input logic [1:0] k);
        t_chan v;
        v = c[17*k +: 17];
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pseudocolor_level_map_unit.sv
// Top level of the pseudocolor level map: pipelined level search and colour interpolation
// Throughput: one request per cycle while the output is not stalled; a 10-stage
// bit-serial level search and a reciprocal-multiply divider set the depth, each
// stage one add/compare or multiply.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid pipeline and loads the default register values.
`default_nettype none
module pseudocolor_level_map_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [15:0]  i_sample,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [8:0]        o_level,
    output logic              o_above_range,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import plmu_pkg::*;

    localparam int NSTG = 11 + SRCH_BITS;
    localparam int LAST = SRCH_BITS - 1;

    // Configuration registers
    logic              r_map_mode;
    logic [15:0]       r_low_value;
    logic [15:0]       r_mid_value;
    logic [15:0]       r_high_value;
    t_color            r_color_low;
    t_color            r_color_middle;
    t_color            r_color_high;
    logic [8:0]        r_level_count;
    logic [2:0]        w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;

    // Write a register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode     <= 1'b0;
            r_low_value    <= 16'd0;
            r_mid_value    <= 16'd0;
            r_high_value   <= 16'd32767;
            r_color_low    <= COLOR_WHITE;
            r_color_middle <= COLOR_WHITE;
            r_color_high   <= COLOR_WHITE;
            r_level_count  <= 9'd16;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAP_MODE:     r_map_mode     <= pwdata[0];
                REG_LOW_VALUE:    r_low_value    <= pwdata[15:0];
                REG_MID_VALUE:    r_mid_value    <= pwdata[15:0];
                REG_HIGH_VALUE:   r_high_value   <= pwdata[15:0];
                REG_COLOR_LOW:    r_color_low    <= pwdata[50:0];
                REG_COLOR_MIDDLE: r_color_middle <= pwdata[50:0];
                REG_COLOR_HIGH:   r_color_high   <= pwdata[50:0];
                REG_LEVEL_COUNT:  r_level_count  <= pwdata[8:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_MAP_MODE:     prdata = {63'd0, r_map_mode};
            REG_LOW_VALUE:    prdata = {48'd0, r_low_value};
            REG_MID_VALUE:    prdata = {48'd0, r_mid_value};
            REG_HIGH_VALUE:   prdata = {48'd0, r_high_value};
            REG_COLOR_LOW:    prdata = {13'd0, r_color_low};
            REG_COLOR_MIDDLE: prdata = {13'd0, r_color_middle};
            REG_COLOR_HIGH:   prdata = {13'd0, r_color_high};
            REG_LEVEL_COUNT:  prdata = {55'd0, r_level_count};
        endcase
    end

    // Derived configuration: clamped count, slopes, top level
    logic [8:0]         w_n;
    logic [7:0]         w_h;
    logic signed [16:0] w_dlin;
    logic signed [16:0] w_dml;
    logic signed [16:0] w_dhm;
    logic               w_dneg;
    logic [16:0]        w_mlin;
    logic [16:0]        w_aml;
    logic [16:0]        w_ahm;
    logic [17:0]        w_ma_div;
    logic [17:0]        w_ma;
    logic [17:0]        w_mb;
    logic               w_lin_dec;
    logic [26:0]        w_nb;
    logic [26:0]        w_ha;
    logic [8:0]         w_top;

    always_comb begin
        priority if (r_level_count == 9'd0) begin
            w_n = 9'd1;
        end else if (r_level_count > 9'(MAX_LEVELS)) begin
            w_n = 9'(MAX_LEVELS);
        end else begin
            w_n = r_level_count;
        end
    end

    assign w_h       = w_n[8:1];
    assign w_dlin    = {r_high_value[15], r_high_value} - {r_low_value[15], r_low_value};
    assign w_dml     = {r_mid_value[15], r_mid_value} - {r_low_value[15], r_low_value};
    assign w_dhm     = {r_high_value[15], r_high_value} - {r_mid_value[15], r_mid_value};
    assign w_dneg    = w_dlin[16];
    assign w_mlin    = w_dneg ? 17'(-w_dlin) : 17'(w_dlin);
    assign w_aml     = w_dml[16] ? 17'(-w_dml) : 17'(w_dml);
    assign w_ahm     = w_dhm[16] ? 17'(-w_dhm) : 17'(w_dhm);
    assign w_ma_div  = {w_aml, 1'b0};
    assign w_mb      = {w_ahm, 1'b0};
    assign w_ma      = r_map_mode ? w_ma_div : {1'b0, w_mlin};
    assign w_lin_dec = !r_map_mode && w_dneg;
    assign w_nb      = 27'(w_n) * 27'(w_mb);
    assign w_ha      = 27'(w_h) * 27'(w_ma_div);

    always_comb begin
        if (!r_map_mode) begin
            w_top = (!w_dneg && (w_dlin != 17'sd0)) ? w_n : 9'd0;
        end else if (w_nb > w_ha) begin
            w_top = w_n;
        end else begin
            w_top = (w_ma_div == 18'd0) ? 9'd0 : {1'b0, w_h};
        end
    end

    // Pipeline control: one enable for every stage
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    assign w_en    = !r_vld[NSTG-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Stage 1: scaled offset of the sample from the low value
    logic signed [16:0] w_sd;
    logic signed [26:0] w_vprod;
    logic signed [25:0] r_v;

    assign w_sd    = {i_sample[15], i_sample} - {r_low_value[15], r_low_value};
    assign w_vprod = w_sd * $signed({1'b0, w_n});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v <= w_vprod[25:0];
        end
    end

    // Stage 2: search limits for both segments
    logic signed [26:0] r_la;
    logic signed [26:0] r_lb;
    logic               r_vp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la <= w_lin_dec ? -{r_v[25], r_v} : {r_v[25], r_v} - 27'sd1;
            r_lb <= {r_v[25], r_v} - 27'sd1;
            r_vp <= !r_v[25] && (r_v != 26'sd0);
        end
    end

    // Search stages: greedy largest x with x*m <= limit, one bit per stage
    logic [SRCH_BITS-1:0] r_xa   [0:LAST];
    logic [SRCH_BITS-1:0] r_xb   [0:LAST];
    logic [27:0]          r_acca [0:LAST];
    logic [27:0]          r_accb [0:LAST];
    logic signed [26:0]   r_sla  [0:LAST];
    logic signed [26:0]   r_slb  [0:LAST];
    logic                 r_svp  [0:LAST];

    for (genvar k = 0; k < SRCH_BITS; k++) begin : g_srch
        localparam int BIT = SRCH_BITS - 1 - k;
        logic [SRCH_BITS-1:0] w_pxa;
        logic [SRCH_BITS-1:0] w_pxb;
        logic [27:0]          w_pacca;
        logic [27:0]          w_paccb;
        logic signed [26:0]   w_pla;
        logic signed [26:0]   w_plb;
        logic                 w_pvp;
        logic [27:0]          w_ta;
        logic [27:0]          w_tb;
        logic                 w_oka;
        logic                 w_okb;

        if (k == 0) begin : g_first
            assign w_pxa   = '0;
            assign w_pxb   = '0;
            assign w_pacca = '0;
            assign w_paccb = '0;
            assign w_pla   = r_la;
            assign w_plb   = r_lb;
            assign w_pvp   = r_vp;
        end else begin : g_next
            assign w_pxa   = r_xa[k-1];
            assign w_pxb   = r_xb[k-1];
            assign w_pacca = r_acca[k-1];
            assign w_paccb = r_accb[k-1];
            assign w_pla   = r_sla[k-1];
            assign w_plb   = r_slb[k-1];
            assign w_pvp   = r_svp[k-1];
        end

        assign w_ta  = w_pacca + (28'(w_ma) << BIT);
        assign w_tb  = w_paccb + (28'(w_mb) << BIT);
        assign w_oka = $signed({1'b0, w_ta}) <= $signed({{2{w_pla[26]}}, w_pla});
        assign w_okb = $signed({1'b0, w_tb}) <= $signed({{2{w_plb[26]}}, w_plb});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_xa[k]   <= w_oka ? (w_pxa | SRCH_BITS'(1 << BIT)) : w_pxa;
                r_acca[k] <= w_oka ? w_ta : w_pacca;
                r_xb[k]   <= w_okb ? (w_pxb | SRCH_BITS'(1 << BIT)) : w_pxb;
                r_accb[k] <= w_okb ? w_tb : w_paccb;
                r_sla[k]  <= w_pla;
                r_slb[k]  <= w_plb;
                r_svp[k]  <= w_pvp;
            end
        end
    end

    // Resolve stage: candidate level of each segment
    logic [10:0] w_fa;
    logic [10:0] w_fb;
    logic [10:0] w_hp1;
    logic [10:0] w_ib;
    logic [8:0]  w_ia;
    logic        w_oka_r;
    logic        w_okb_r;
    logic [8:0]  r_ia;
    logic [8:0]  r_ib;
    logic        r_oka;
    logic        r_okb;

    assign w_fa  = r_svp[LAST] ? 11'(r_xa[LAST]) + 11'd1 : 11'd0;
    assign w_fb  = r_svp[LAST] ? 11'(r_xb[LAST]) + 11'd1 : 11'd0;
    assign w_hp1 = 11'(w_h) + 11'd1;

    always_comb begin
        w_ib    = 11'd0;
        w_okb_r = 1'b0;
        if (r_map_mode) begin
            w_oka_r = w_fa <= 11'(w_h);
            w_ia    = w_fa[8:0];
            w_ib    = (w_fb > w_hp1) ? w_fb : w_hp1;
            w_okb_r = w_ib <= 11'(w_n);
        end else if (w_lin_dec) begin
            w_oka_r = !r_svp[LAST];
            w_ia    = (r_xa[LAST] > 10'(w_n)) ? w_n : r_xa[LAST][8:0];
        end else begin
            w_oka_r = w_fa <= 11'(w_n);
            w_ia    = w_fa[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ia  <= w_ia;
            r_ib  <= w_ib[8:0];
            r_oka <= w_oka_r;
            r_okb <= w_okb_r;
        end
    end

    // Key stage: relative keys of both candidates
    logic [26:0] r_ka;
    logic [26:0] r_kb;
    logic [8:0]  r_ia2;
    logic [8:0]  r_ib2;
    logic        r_oka2;
    logic        r_okb2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ka   <= 27'(r_ia) * 27'(w_ma);
            r_kb   <= 27'(r_ib) * 27'(w_mb);
            r_ia2  <= r_ia;
            r_ib2  <= r_ib;
            r_oka2 <= r_oka;
            r_okb2 <= r_okb;
        end
    end

    // Pick stage: smallest key, earlier level on a tie, else saturate
    logic [8:0] w_lvl;
    logic       w_abv;
    logic [8:0] r_lvl_d [0:5];
    logic       r_abv_d [0:5];

    always_comb begin
        w_abv = 1'b0;
        priority if (r_oka2 && (!r_okb2 || (r_ka <= r_kb))) begin
            w_lvl = r_ia2;
        end else if (r_okb2) begin
            w_lvl = r_ib2;
        end else begin
            w_lvl = w_top;
            w_abv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lvl_d[0] <= w_lvl;
            r_abv_d[0] <= w_abv;
            for (int k = 1; k < 6; k++) begin
                r_lvl_d[k] <= r_lvl_d[k-1];
                r_abv_d[k] <= r_abv_d[k-1];
            end
        end
    end

    // Weight stage: segment weights and end colours
    logic [9:0] w_lvl2;
    logic       w_lower;
    logic [9:0] w_wt;
    t_color     w_ca;
    t_color     w_cb;
    logic [8:0] r_w;
    logic [8:0] r_nw;
    t_chan      r_ca [0:2];
    t_chan      r_cb [0:2];

    assign w_lvl2  = {r_lvl_d[0], 1'b0};
    assign w_lower = w_lvl2 <= {1'b0, w_n};

    always_comb begin
        if (!r_map_mode) begin
            w_wt = {1'b0, r_lvl_d[0]};
            w_ca = r_color_low;
            w_cb = r_color_high;
        end else if (w_lower) begin
            w_wt = w_lvl2;
            w_ca = r_color_low;
            w_cb = r_color_middle;
        end else begin
            w_wt = w_lvl2 - {1'b0, w_n};
            w_ca = r_color_middle;
            w_cb = r_color_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w  <= w_wt[8:0];
            r_nw <= w_n - w_wt[8:0];
            for (int k = 0; k < 3; k++) begin
                r_ca[k] <= chan_q16(w_ca, 2'(k));
                r_cb[k] <= chan_q16(w_cb, 2'(k));
            end
        end
    end

    // Multiply, sum, reciprocal divide, correct and saturate per channel
    logic [24:0]      r_pa   [0:2];
    logic [24:0]      r_pb   [0:2];
    logic [24:0]      r_num  [0:2];
    logic [24:0]      r_num3 [0:2];
    logic [24:0]      r_q    [0:2];
    logic [24:0]      r_q4   [0:2];
    logic [9:0]       r_rem  [0:2];
    logic [RCP_W-1:0] r_rcp;
    logic [7:0]       r_byte [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [50:0] w_prod;
        logic [33:0] w_qn;
        logic [33:0] w_rem;
        logic [24:0] w_c;

        assign w_prod = 51'(r_num[c]) * 51'(r_rcp);
        assign w_qn   = 34'(r_q[c]) * 34'(w_n);
        assign w_rem  = 34'(r_num3[c]) - w_qn;
        assign w_c    = (r_rem[c] >= 10'(w_n)) ? r_q4[c] + 25'd1 : r_q4[c];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa[c]   <= 25'(r_ca[c]) * 25'(r_nw);
                r_pb[c]   <= 25'(r_cb[c]) * 25'(r_w);
                r_num[c]  <= r_pa[c] + r_pb[c];
                r_q[c]    <= w_prod[49:25];
                r_num3[c] <= r_num[c];
                r_q4[c]   <= r_q[c];
                r_rem[c]  <= w_rem[9:0];
                r_byte[c] <= (w_c >= 25'(Q16_ONE)) ? 8'hFF : w_c[15:8];
            end
        end
    end

    // Hold the reciprocal of the level count for the divide stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rcp <= RCP_TBL[w_n];
        end
    end

    // Output register
    logic [8:0] r_level;
    logic       r_above;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_level <= r_lvl_d[5];
            r_above <= r_abv_d[5];
        end
    end

    assign o_red         = r_byte[0];
    assign o_green       = r_byte[1];
    assign o_blue        = r_byte[2];
    assign o_level       = r_level;
    assign o_above_range = r_above;

endmodule
`default_nettype wire

>>> hdl/plmu_checker.sv
// Port checker of the pseudocolor level map and its bind
`default_nettype none
`include "pseudocolor_level_map_unit_macros.svh"
module plmu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_ready,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic [7:0] o_red,
    input wire logic [7:0] o_green,
    input wire logic [7:0] o_blue,
    input wire logic [8:0] o_level,
    input wire logic       o_above_range
);

    // Hold a stalled result
    `PLMU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_level) && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_above_range))

    // Drop input ready while the output is stalled
    `PLMU_ASSERT_IMP(a_backpressure, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)

    // Keep the level index within the level table
    `PLMU_ASSERT_IMP(a_level_range, i_clk, i_rst_n, o_valid, o_level <= 9'd256)

endmodule

bind pseudocolor_level_map_unit plmu_checker u_plmu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_ready       (i_ready),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_level       (o_level),
    .o_above_range (o_above_range)
);
`default_nettype wire

>>> tb/tb.sv
// Testbench for the pseudocolor level map: directed table, random samples, predictor check
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import plmu_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] level;
        logic       above;
    } t_pixel;

    typedef struct {
        logic [15:0] sample;
        logic        known;
        t_pixel      pix;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_sample = '0;
    logic        i_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [8:0]  o_level;
    logic        o_above_range;
    logic [63:0] prdata;
    logic        pready;

    // Predictor copy of the map registers
    logic        cfg_mode;
    logic [15:0] cfg_low;
    logic [15:0] cfg_mid;
    logic [15:0] cfg_high;
    logic [50:0] cfg_col_low;
    logic [50:0] cfg_col_mid;
    logic [50:0] cfg_col_high;
    logic [8:0]  cfg_count;

    t_pixel pixel_queue[$];
    int     mismatches = 0;
    int     pixels_seen = 0;
    int     idle_cycles = 0;
    int     requests_sent = 0;
    int     above_seen = 0;
    bit     stall_mode = 1'b0;

    pseudocolor_level_map_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sample(i_sample), .o_valid(o_valid), .i_ready(i_ready), .o_red(o_red),
        .o_green(o_green), .o_blue(o_blue), .o_level(o_level),
        .o_above_range(o_above_range), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Clamp one packed Q16 channel at one
    function automatic longint unsigned q16_of(logic [50:0] c, int k);
        longint unsigned v;
        v = (c >> (17 * k)) & 64'h1FFFF;
        return (v > 65536) ? 65536 : v;
    endfunction

    // Key of level i, scaled by n
    function automatic longint key_of(longint i, longint n);
        longint lo;
        longint mid;
        longint hi;
        lo  = longint'($signed(cfg_low));
        mid = longint'($signed(cfg_mid));
        hi  = longint'($signed(cfg_high));
        if (!cfg_mode) return lo * n + i * (hi - lo);
        if (2 * i <= n) return lo * n + 2 * i * ((mid >= lo) ? mid - lo : lo - mid);
        return lo * n + 2 * i * ((hi >= mid) ? hi - mid : mid - hi);
    endfunction

    function automatic logic [7:0] byte_of(longint unsigned i, longint unsigned n, int k);
        longint unsigned cl;
        longint unsigned cm;
        longint unsigned ch;
        longint unsigned num;
        longint unsigned c;
        cl = q16_of(cfg_col_low, k);
        cm = q16_of(cfg_col_mid, k);
        ch = q16_of(cfg_col_high, k);
        if (!cfg_mode) num = cl * (n - i) + ch * i;
        else if (2 * i <= n) num = cm * (2 * i) + cl * (n - 2 * i);
        else num = ch * (2 * i - n) + cm * (2 * n - 2 * i);
        c = num / n;
        return (c >= 65536) ? 8'd255 : 8'(c >> 8);
    endfunction

    // Pick the level for one sample under the current map
    function automatic t_pixel map_sample(logic [15:0] s);
        longint n;
        longint target;
        longint key;
        longint best;
        longint top;
        longint best_key;
        longint top_key;
        t_pixel p;
        n = cfg_count;
        if (n < 1) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        target = longint'($signed(s)) * n;
        best = -1; top = -1; best_key = 0; top_key = 0;
        for (longint i = 0; i <= n; i++) begin
            key = key_of(i, n);
            if (key >= target && (best < 0 || key < best_key)) begin
                best = i; best_key = key;
            end
            if (top < 0 || key > top_key) begin
                top = i; top_key = key;
            end
        end
        p.above = (best < 0);
        if (best < 0) best = top;
        p.red   = byte_of(best, n, 0);
        p.green = byte_of(best, n, 1);
        p.blue  = byte_of(best, n, 2);
        p.level = 9'(best);
        return p;
    endfunction

    // Write one map register over APB, mirror it in the predictor
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(idx) << 3; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MAP_MODE:     cfg_mode = value[0];
            REG_LOW_VALUE:    cfg_low = value[15:0];
            REG_MID_VALUE:    cfg_mid = value[15:0];
            REG_HIGH_VALUE:   cfg_high = value[15:0];
            REG_COLOR_LOW:    cfg_col_low = value[50:0];
            REG_COLOR_MIDDLE: cfg_col_mid = value[50:0];
            REG_COLOR_HIGH:   cfg_col_high = value[50:0];
            REG_LEVEL_COUNT:  cfg_count = value[8:0];
            default: ;
        endcase
    endtask

    task automatic load_map(logic mode, logic [15:0] lo, logic [15:0] mid, logic [15:0] hi,
                            logic [50:0] cl, logic [50:0] cm, logic [50:0] ch,
                            logic [8:0] n);
        write_reg(REG_MAP_MODE, 64'(mode));
        write_reg(REG_LOW_VALUE, 64'(lo));
        write_reg(REG_MID_VALUE, 64'(mid));
        write_reg(REG_HIGH_VALUE, 64'(hi));
        write_reg(REG_COLOR_LOW, 64'(cl));
        write_reg(REG_COLOR_MIDDLE, 64'(cm));
        write_reg(REG_COLOR_HIGH, 64'(ch));
        write_reg(REG_LEVEL_COUNT, 64'(n));
    endtask

    // Send one sample request; hold valid until accepted
    task automatic send_sample(logic [15:0] s, t_pixel pix);
        @(negedge i_clk);
        i_valid <= 1'b1; i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        pixel_queue.push_back(pix);
        requests_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [50:0] rand_color();
        logic [16:0] ch [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0: ch[k] = 17'h10000;
                1: ch[k] = 17'($urandom);
                default: ch[k] = 17'($urandom_range(0, 65536));
            endcase
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // Receiver stall pattern: alternate between free-running and choppy spells
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        i_ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // Compare each pixel with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_red, o_green, o_blue, o_level, o_above_range};
            pixels_seen++;
            if (got.above) above_seen++;
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %p", got);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, pixel or register access
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    t_row rows[$];

    initial begin
        int burst;
        logic [15:0] s;
        logic [15:0] probes[$];
        cfg_mode = 1'b0; cfg_low = '0; cfg_mid = '0; cfg_high = 16'h7FFF;
        cfg_col_low = COLOR_WHITE; cfg_col_mid = COLOR_WHITE; cfg_col_high = COLOR_WHITE;
        cfg_count = 9'd16;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset: all white, 16 levels over [0, 32767]
        rows.push_back('{16'h8000, 1'b1, '{8'd255, 8'd255, 8'd255, 9'd0, 1'b0}});
        rows.push_back('{16'h0000, 1'b1, '{8'd255, 8'd255, 8'd255, 9'd0, 1'b0}});
        rows.push_back('{16'h7FFF, 1'b1, '{8'd255, 8'd255, 8'd255, 9'd16, 1'b0}});
        rows.push_back('{16'h0001, 1'b0, '0});
        foreach (rows[r]) send_sample(rows[r].sample,
                                      rows[r].known ? rows[r].pix : map_sample(rows[r].sample));
        drop_valid();
        drain();
        rows.delete();

        // Linear black to white, 1 level: top saturates with above flag
        load_map(1'b0, 16'hFFF0, 16'h0000, 16'h0010, 51'd0, COLOR_WHITE, COLOR_WHITE, 9'd1);
        rows.push_back('{16'h7FFF, 1'b1, '{8'd255, 8'd255, 8'd255, 9'd1, 1'b1}});
        rows.push_back('{16'h8000, 1'b1, '{8'd0, 8'd0, 8'd0, 9'd0, 1'b0}});
        rows.push_back('{16'h0010, 1'b1, '{8'd255, 8'd255, 8'd255, 9'd1, 1'b0}});
        rows.push_back('{16'h0000, 1'b0, '0});
        foreach (rows[r]) send_sample(rows[r].sample,
                                      rows[r].known ? rows[r].pix : map_sample(rows[r].sample));
        drop_valid();
        drain();
        rows.delete();

        // Reversed keys, channels above one, level count zero and above the limit
        load_map(1'b0, 16'h7FFF, 16'h0, 16'h8000, {3{17'h1FFFF}}, 51'd0, 51'h12345_6789A, 9'd0);
        probes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hC000};
        foreach (probes[j]) send_sample(probes[j], map_sample(probes[j]));
        drop_valid();
        drain();
        write_reg(REG_LEVEL_COUNT, 64'd511);
        probes = '{16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF};
        foreach (probes[j]) send_sample(probes[j], map_sample(probes[j]));
        drop_valid();
        drain();

        // Diverging map, mid below low and odd level count
        load_map(1'b1, 16'h0100, 16'hFF00, 16'h7000, 51'h0_0001_0000, 51'h1_0000_0000,
                 51'h4000_0000_0000, 9'd7);
        probes = '{16'h8000, 16'h7FFF, 16'h0100, 16'h0000, 16'h0300};
        foreach (probes[j]) send_sample(probes[j], map_sample(probes[j]));
        drop_valid();
        drain();

        // Random phases: new map per phase, bursty samples near and across the keys
        for (int phase = 0; phase < 15; phase++) begin
            load_map(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     rand_color(), rand_color(), rand_color(),
                     (phase % 5 == 0) ? 9'($urandom) : 9'($urandom_range(1, 24)));
            for (int k = 0; k < RANDOM_ITEMS / 15; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && k < RANDOM_ITEMS / 15; b++) begin
                    case ($urandom_range(0, 3))
                        0: s = 16'($urandom);
                        1: s = cfg_low + 16'($urandom_range(0, 8)) - 16'd4;
                        2: s = cfg_high + 16'($urandom_range(0, 8)) - 16'd4;
                        default: s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    endcase
                    send_sample(s, map_sample(s));
                    k++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    drop_valid();
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end
            drop_valid();
            drain();
        end

        $display("Sent %0d samples over %0d map settings; %0d pixels checked, %0d above range.",
                 requests_sent, 20, pixels_seen, above_seen);
        if (mismatches == 0 && pixel_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
